/* design/sorted_value_table_unit_defines.svh */
// assertion macros used by the sorted value table unit
`ifndef SORTED_VALUE_TABLE_UNIT_DEFINES_SVH
`define SORTED_VALUE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define SVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted value table check failed");

// next-cycle implication
`define SVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted value table check failed");

`endif

/* design/svt_pkg.sv */
package svt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int WORD_W       = 32;
    localparam int INDEX_W      = 6;
    localparam int COUNT_W      = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

endpackage

/* design/svt_ram.sv */
module svt_ram #(
    parameter int DEPTH = svt_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [svt_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]                     raddr,
    output logic signed [svt_pkg::WORD_W-1:0] rdata
);

    logic signed [svt_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* design/sorted_value_table_unit.sv */
// Sorted table of signed 32-bit words held in ascending order in a memory with one
// write port and one registered read port, CAPACITY entries deep. One operation word
// is taken at a time; in_stall is high from acceptance until the sequencer returns to
// idle. Each operation runs a compare-and-shift scan over the memory's one registered
// read port, each entry read in a read state and compared in a compare state; the
// entries scanned are those above the value for insert, the full count for remove,
// none for read or for a refused insert. A finished result cannot leave while the
// previous one still waits on out_stall. After the scan the first and last entries
// are read, when the table is not empty. The result word sits in an output register,
// so the next operation is taken while it waits.
`include "sorted_value_table_unit_defines.svh"

module sorted_value_table_unit #(
    parameter int CAPACITY = svt_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic signed [svt_pkg::WORD_W-1:0]  value,
    input  logic [svt_pkg::INDEX_W-1:0]        index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic signed [svt_pkg::WORD_W-1:0]  read_value,
    output logic [svt_pkg::COUNT_W-1:0]        entry_count,
    output logic signed [svt_pkg::WORD_W-1:0]  smallest,
    output logic signed [svt_pkg::WORD_W-1:0]  largest,
    output logic                               is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_REM_RD,
        S_REM_CMP,
        S_GET_RD,
        S_GET_CAP,
        S_MIN_RD,
        S_MIN_CAP,
        S_MAX_CAP,
        S_DONE
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     ptr_reg, ptr_next;
    logic                              found_reg, found_next;
    logic signed [svt_pkg::WORD_W-1:0] value_reg, value_next;
    logic [svt_pkg::INDEX_W-1:0]       index_reg, index_next;
    svt_pkg::status_t                  stat_reg, stat_next;
    logic signed [svt_pkg::WORD_W-1:0] rd_reg, rd_next;
    logic signed [svt_pkg::WORD_W-1:0] min_reg, min_next;
    logic signed [svt_pkg::WORD_W-1:0] max_reg, max_next;

    logic                              out_valid_reg, out_valid_next;
    svt_pkg::status_t                  out_status_reg, out_status_next;
    logic signed [svt_pkg::WORD_W-1:0] out_read_reg, out_read_next;
    logic [svt_pkg::COUNT_W-1:0]       out_count_reg, out_count_next;
    logic signed [svt_pkg::WORD_W-1:0] out_min_reg, out_min_next;
    logic signed [svt_pkg::WORD_W-1:0] out_max_reg, out_max_next;
    logic                              out_empty_reg, out_empty_next;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [svt_pkg::WORD_W-1:0] mem_wdata;
    logic [AW-1:0]                     mem_raddr;
    logic signed [svt_pkg::WORD_W-1:0] mem_rdata;

    // shared compare unit
    logic                              cmp_greater;
    logic                              cmp_equal;

    assign cmp_greater = mem_rdata > value_reg;
    assign cmp_equal   = mem_rdata == value_reg;

    svt_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        found_next      = found_reg;
        value_next      = value_reg;
        index_next      = index_reg;
        stat_next       = stat_reg;
        rd_next         = rd_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_read_next   = out_read_reg;
        out_count_next  = out_count_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_empty_next  = out_empty_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = value_reg;
        mem_raddr       = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = value;
                    index_next = index;
                    stat_next  = svt_pkg::ST_OK;
                    rd_next    = '0;
                    found_next = 1'b0;
                    case (opcode)
                        svt_pkg::OP_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                stat_next  = svt_pkg::ST_FULL;
                                state_next = S_MIN_RD;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        svt_pkg::OP_REMOVE:
                        begin
                            ptr_next   = '0;
                            state_next = S_REM_RD;
                        end
                        svt_pkg::OP_READ:
                        begin
                            state_next = S_GET_RD;
                        end
                        default:
                        begin
                            state_next = S_MIN_RD;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = value_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_MIN_RD;
                end
                else
                begin
                    mem_raddr  = AW'(ptr_reg - CW'(1));
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ptr_reg);
                if (cmp_greater)
                begin
                    mem_wdata  = mem_rdata;
                    ptr_next   = ptr_reg - CW'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    mem_wdata  = value_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_MIN_RD;
                end
            end
            S_REM_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        stat_next = svt_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_MIN_RD;
                end
                else
                begin
                    mem_raddr  = AW'(ptr_reg);
                    state_next = S_REM_CMP;
                end
            end
            S_REM_CMP:
            begin
                // close the gap once the match is behind us
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(ptr_reg - CW'(1));
                    mem_wdata = mem_rdata;
                end
                else if (cmp_equal)
                begin
                    found_next = 1'b1;
                end
                ptr_next   = ptr_reg + CW'(1);
                state_next = S_REM_RD;
            end
            S_GET_RD:
            begin
                if (32'(index_reg) < 32'(count_reg))
                begin
                    mem_raddr  = AW'(index_reg);
                    state_next = S_GET_CAP;
                end
                else
                begin
                    stat_next  = svt_pkg::ST_RANGE;
                    state_next = S_MIN_RD;
                end
            end
            S_GET_CAP:
            begin
                rd_next    = mem_rdata;
                mem_raddr  = '0;
                state_next = S_MIN_CAP;
            end
            S_MIN_RD:
            begin
                if (count_reg == '0)
                begin
                    min_next   = '0;
                    max_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = '0;
                    state_next = S_MIN_CAP;
                end
            end
            S_MIN_CAP:
            begin
                min_next   = mem_rdata;
                mem_raddr  = AW'(count_reg - CW'(1));
                state_next = S_MAX_CAP;
            end
            S_MAX_CAP:
            begin
                max_next   = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_read_next   = rd_reg;
                    out_count_next  = svt_pkg::COUNT_W'(count_reg);
                    out_min_next    = min_reg;
                    out_max_next    = max_reg;
                    out_empty_next  = (count_reg == '0);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        found_reg      <= found_next;
        value_reg      <= value_next;
        index_reg      <= index_next;
        stat_reg       <= stat_next;
        rd_reg         <= rd_next;
        min_reg        <= min_next;
        max_reg        <= max_next;
        out_status_reg <= out_status_next;
        out_read_reg   <= out_read_next;
        out_count_reg  <= out_count_next;
        out_min_reg    <= out_min_next;
        out_max_reg    <= out_max_next;
        out_empty_reg  <= out_empty_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign read_value  = out_read_reg;
    assign entry_count = out_count_reg;
    assign smallest    = out_min_reg;
    assign largest     = out_max_reg;
    assign is_empty    = out_empty_reg;

    `SVT_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `SVT_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1,
        count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1) ||
        count_reg == $past(count_reg) - CW'(1))
    `SVT_ASSERT_NOW(a_rem_ptr, clk, rst_n, state_reg == S_REM_RD, ptr_reg <= count_reg)
    `SVT_ASSERT_NOW(a_ins_room, clk, rst_n, state_reg == S_INS_CMP,
        ptr_reg != '0 && count_reg < CW'(CAPACITY))
    `SVT_ASSERT_NEXT(a_idle_hold, clk, rst_n, state_reg == S_IDLE, $stable(count_reg))

endmodule

/* verif/tb.sv */
module tb;

    localparam int TABLE_DEPTH    = svt_pkg::CAPACITY_DEF;
    localparam int RANDOM_WORDS   = 1950;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 400;

    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct {
        logic [1:0]                         opcode;
        logic signed [svt_pkg::WORD_W-1:0]  value;
        logic [svt_pkg::INDEX_W-1:0]        index;
        bit                                 hold;
    } table_word_t;

    typedef struct {
        svt_pkg::status_t                   status;
        logic signed [svt_pkg::WORD_W-1:0]  read_value;
        logic [svt_pkg::COUNT_W-1:0]        entry_count;
        logic signed [svt_pkg::WORD_W-1:0]  smallest;
        logic signed [svt_pkg::WORD_W-1:0]  largest;
        logic                               is_empty;
    } table_reply_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [1:0]                          opcode;
    logic signed [svt_pkg::WORD_W-1:0]   value;
    logic [svt_pkg::INDEX_W-1:0]         index;
    logic                                out_valid;
    logic                                out_stall;
    logic [1:0]                          status;
    logic signed [svt_pkg::WORD_W-1:0]   read_value;
    logic [svt_pkg::COUNT_W-1:0]         entry_count;
    logic signed [svt_pkg::WORD_W-1:0]   smallest;
    logic signed [svt_pkg::WORD_W-1:0]   largest;
    logic                                is_empty;

    table_word_t                         pending_ops[$];
    table_reply_t                        expected_replies[$];
    logic signed [svt_pkg::WORD_W-1:0]   held_values[$];
    logic signed [svt_pkg::WORD_W-1:0]   issued_values[$];

    int mismatches    = 0;
    int words_in      = 0;
    int replies_out   = 0;
    int full_refusals = 0;
    int remove_misses = 0;
    int range_reads   = 0;
    int peak_depth    = 0;
    int gap_left      = 0;
    int burst_left    = 0;
    int stall_mode    = 0;
    int stall_phase   = 0;
    int stall_tick    = 0;
    int idle_cycles   = 0;

    sorted_value_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .value       (value),
        .index       (index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .smallest    (smallest),
        .largest     (largest),
        .is_empty    (is_empty)
    );

    initial clk = 1'b0;

    always #10 clk = ~clk;

    // sorted table held as an ascending queue
    function automatic table_reply_t apply_table_op(table_word_t w);
        table_reply_t r;
        int           pos;
        r.status     = svt_pkg::ST_OK;
        r.read_value = '0;
        case (w.opcode)
            svt_pkg::OP_INSERT:
            begin
                if (held_values.size() >= TABLE_DEPTH)
                begin
                    r.status = svt_pkg::ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_values.size() && held_values[pos] <= w.value)
                        pos++;
                    held_values.insert(pos, w.value);
                end
            end
            svt_pkg::OP_REMOVE:
            begin
                pos = 0;
                while (pos < held_values.size() && held_values[pos] != w.value)
                    pos++;
                if (pos >= held_values.size())
                begin
                    r.status = svt_pkg::ST_NOT_FOUND;
                    remove_misses++;
                end
                else
                    held_values.delete(pos);
            end
            svt_pkg::OP_READ:
            begin
                if (int'(w.index) < held_values.size())
                    r.read_value = held_values[w.index];
                else
                begin
                    r.status = svt_pkg::ST_RANGE;
                    range_reads++;
                end
            end
            default:
            begin
            end
        endcase
        if (held_values.size() > peak_depth)
            peak_depth = held_values.size();
        r.entry_count = svt_pkg::COUNT_W'(held_values.size());
        r.smallest    = held_values.size() != 0 ? held_values[0] : '0;
        r.largest     = held_values.size() != 0 ? held_values[$] : '0;
        r.is_empty    = held_values.size() == 0;
        return r;
    endfunction

    function automatic logic signed [svt_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0000 + $urandom_range(0, 15);
            3: return 32'sh7fff_fff0 + $urandom_range(0, 15);
            4, 5, 6: return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [1:0] op, logic signed [svt_pkg::WORD_W-1:0] v,
                            logic [svt_pkg::INDEX_W-1:0] idx, bit hold);
        table_word_t w;
        w.opcode = op;
        w.value  = v;
        w.index  = idx;
        w.hold   = hold;
        pending_ops.push_back(w);
        if (op == svt_pkg::OP_INSERT)
            issued_values.push_back(v);
    endtask

    task automatic check_field(string name, logic [svt_pkg::WORD_W-1:0] want,
                               logic [svt_pkg::WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        int mode;
        int seg;
        int seg_len;
        int k;
        int n;
        int roll;
        int pick;
        bit hold;
        logic [1:0] op;
        logic signed [svt_pkg::WORD_W-1:0] v;
        logic [svt_pkg::INDEX_W-1:0] idx;

        rst_n = 1'b0;

        // empty table, extremes, duplicates, misses and ignored opcode
        queue_op(svt_pkg::OP_READ,   $urandom, 6'd0, 1'b0);
        queue_op(svt_pkg::OP_REMOVE, 32'sd5, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(OP_NOP,             $urandom, 6'd63, 1'b0);
        queue_op(svt_pkg::OP_INSERT, 32'sd0, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_INSERT, 32'sh7fff_ffff, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_INSERT, 32'sh8000_0000, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_INSERT, 32'sd0, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_INSERT, -32'sd1, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_READ,   $urandom, 6'd0, 1'b0);
        queue_op(svt_pkg::OP_READ,   $urandom, 6'd4, 1'b0);
        queue_op(svt_pkg::OP_READ,   $urandom, 6'd5, 1'b0);
        queue_op(svt_pkg::OP_READ,   $urandom, 6'd63, 1'b0);
        queue_op(svt_pkg::OP_REMOVE, 32'sd12345, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_REMOVE, 32'sd0, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_REMOVE, 32'sh8000_0000, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(OP_NOP,             $urandom, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_REMOVE, 32'sh7fff_ffff, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_READ,   $urandom, 6'd1, 1'b0);
        queue_op(svt_pkg::OP_REMOVE, 32'sd0, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_REMOVE, -32'sd1, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_REMOVE, 32'sd0, svt_pkg::INDEX_W'($urandom), 1'b0);
        queue_op(svt_pkg::OP_INSERT, 32'sd1, svt_pkg::INDEX_W'($urandom), 1'b0);

        // fill, drain and mixed segments; the first one is always a fill segment
        n   = 0;
        seg = 0;
        while (n < RANDOM_WORDS)
        begin
            mode    = (seg == 0) ? MODE_FILL : $urandom_range(MODE_FILL, MODE_MIXED);
            seg_len = (seg == 0) ? 150 : $urandom_range(30, 180);
            for (k = 0; k < seg_len && n < RANDOM_WORDS; k++)
            begin
                roll = $urandom_range(0, 99);
                hold = (k == 0) && (seg % 4 == 1);
                case (mode)
                    MODE_FILL:
                        op = roll < 78 ? svt_pkg::OP_INSERT : roll < 86 ? svt_pkg::OP_REMOVE :
                             roll < 97 ? svt_pkg::OP_READ : OP_NOP;
                    MODE_DRAIN:
                        op = roll < 12 ? svt_pkg::OP_INSERT : roll < 75 ? svt_pkg::OP_REMOVE :
                             roll < 96 ? svt_pkg::OP_READ : OP_NOP;
                    default:
                        op = roll < 40 ? svt_pkg::OP_INSERT : roll < 72 ? svt_pkg::OP_REMOVE :
                             roll < 96 ? svt_pkg::OP_READ : OP_NOP;
                endcase
                v   = $urandom;
                idx = svt_pkg::INDEX_W'($urandom);
                if (op == svt_pkg::OP_INSERT)
                    v = pick_value();
                else if (op == svt_pkg::OP_REMOVE)
                begin
                    if (issued_values.size() != 0 && $urandom_range(0, 4) != 0)
                    begin
                        pick = $urandom_range(0, issued_values.size() - 1);
                        v    = issued_values[pick];
                        issued_values.delete(pick);
                    end
                    else
                        v = pick_value();
                end
                else if (op == svt_pkg::OP_READ && $urandom_range(0, 1) == 0)
                    idx = svt_pkg::INDEX_W'($urandom_range(0, 7));
                queue_op(op, v, idx, hold);
                if (op != OP_NOP)
                    n++;
            end
            seg++;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d replies checked, peak depth %0d of %0d",
                 words_in, replies_out, peak_depth, TABLE_DEPTH);
        $display("refused as full %0d, remove misses %0d, reads out of range %0d",
                 full_refusals, remove_misses, range_reads);
        if (mismatches == 0)
            $display("sorted_value_table_unit: match");
        else
            $display("sorted_value_table_unit: mismatch");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : word_driver
        logic launch;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode   <= svt_pkg::OP_INSERT;
            value    <= '0;
            index    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_replies.push_back(apply_table_op(pending_ops.pop_front()));
                words_in++;
            end
            if (!(in_valid && in_stall))
            begin
                launch = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].hold && expected_replies.size() != 0))
                begin
                    launch = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(40, 120) : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                if (launch)
                begin
                    in_valid <= 1'b1;
                    opcode   <= pending_ops[0].opcode;
                    value    <= pending_ops[0].value;
                    index    <= pending_ops[0].index;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        table_reply_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                replies_out++;
                if (expected_replies.size() == 0)
                begin
                    $error("reply word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("read_value", want.read_value, read_value);
                    check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                    check_field("smallest", want.smallest, smallest);
                    check_field("largest", want.largest, largest);
                    check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
                end
            end
            // stall pattern: none, light, heavy, periodic
            if (stall_phase == 0)
            begin
                stall_mode  = $urandom_range(0, 3);
                stall_phase = $urandom_range(50, 400);
            end
            else
                stall_phase--;
            stall_tick++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (stall_tick % 7) < 3;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sorted_value_table_unit: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* filelist.f */
+incdir+design
design/svt_pkg.sv
design/svt_ram.sv
design/sorted_value_table_unit.sv
verif/tb.sv
